// ----- src/dxt_block_decoder_assert.svh -----
// Assertion shorthands for the block decoder. Both sample on clk and stay quiet during rst.
`ifndef DXT_BLOCK_DECODER_ASSERT_SVH
`define DXT_BLOCK_DECODER_ASSERT_SVH

// ante holds -> cons holds in the same cycle
`define DXT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dxt block decoder: assertion failed");

// ante holds -> cons holds in the next cycle
`define DXT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dxt block decoder: assertion failed");

`endif

// ----- src/dxt_pkg.sv -----
package dxt_pkg;

  // block_format codes; code 3 decodes as DXT4/5
  localparam logic [1:0] FMT_DXT1 = 2'd0;
  localparam logic [1:0] FMT_DXT3 = 2'd1;
  localparam logic [1:0] FMT_DXT5 = 2'd2;

  // channel slots in a palette entry
  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;

  typedef struct packed {
    logic [63:0] color_block;
    logic [63:0] alpha_block;
  } dxt_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [3:0] texel_index;
    logic       last;
  } dxt_texel_t;

  // decoded palettes of one block plus its per-texel indices
  typedef struct packed {
    logic [3:0][2:0][7:0] color;  // entry, channel
    logic [7:0][7:0]      apal;   // DXT5 alpha palette
    logic                 four;   // four-color palette in use
    logic [1:0]           fmt;
    logic [31:0]          cidx;   // 2-bit color index per texel
    logic [63:0]          ablk;   // raw alpha half (nibbles or 3-bit indices)
  } dxt_pal_t;

  // round(v*255/31): reciprocal multiply, exact for all 13-bit numerators here
  function automatic logic [7:0] widen5(input logic [4:0] v);
    logic [12:0] x;
    logic [28:0] p;
    x = 13'(v) * 13'd255 + 13'd15;
    p = 29'(x) * 29'd33826;
    return p[27:20];
  endfunction

  // round(v*255/63)
  function automatic logic [7:0] widen6(input logic [5:0] v);
    logic [13:0] x;
    logic [28:0] p;
    x = 14'(v) * 14'd255 + 14'd31;
    p = 29'(x) * 29'd16645;
    return p[27:20];
  endfunction

  // x/3 for x < 768 (quotient fits in 8 bits)
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [20:0] p;
    p = 21'(x) * 21'd1366;
    return p[19:12];
  endfunction

  // x/7 for x < 1792 (quotient fits in 8 bits)
  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [22:0] p;
    p = 23'(x) * 23'd2341;
    return p[21:14];
  endfunction

  // x/5 for x < 1280 (quotient fits in 8 bits)
  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [22:0] p;
    p = 23'(x) * 23'd3277;
    return p[21:14];
  endfunction

endpackage

// ----- src/dxt_pal.sv -----
module dxt_pal (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  dxt_pkg::dxt_in_t blk,
  input  logic [1:0]       fmt,
  output logic             pal_valid,
  input  logic             pal_ready,
  output dxt_pkg::dxt_pal_t pal
);
  import dxt_pkg::*;

  // stage 1: captured block
  logic        s1_valid;
  logic        s1_ready;
  dxt_in_t     s1_blk;
  logic [1:0]  s1_fmt;

  // stage 2: widened endpoints, alpha numerators
  logic                 s2_valid;
  logic                 s2_ready;
  logic [2:0][7:0]      s2_e0;
  logic [2:0][7:0]      s2_e1;
  logic                 s2_four;
  logic                 s2_seven;
  logic [5:0][10:0]     s2_anum;
  logic [1:0]           s2_fmt;
  logic [31:0]          s2_cidx;
  logic [63:0]          s2_ablk;

  // stage 3: color numerators, alpha palette
  logic                 s3_valid;
  logic                 s3_ready;
  logic [2:0][7:0]      s3_e0;
  logic [2:0][7:0]      s3_e1;
  logic [2:0][9:0]      s3_n2;
  logic [2:0][9:0]      s3_n3;
  logic                 s3_four;
  logic [7:0][7:0]      s3_apal;
  logic [1:0]           s3_fmt;
  logic [31:0]          s3_cidx;
  logic [63:0]          s3_ablk;

  // stage 4: finished palette
  logic                 s4_valid;
  logic                 s4_ready;
  dxt_pal_t             s4_pal;

  logic [2:0][7:0]      e0_next;
  logic [2:0][7:0]      e1_next;
  logic                 four_next;
  logic                 seven_next;
  logic [5:0][10:0]     anum_next;
  logic [2:0][9:0]      n2_next;
  logic [2:0][9:0]      n3_next;
  logic [7:0][7:0]      apal_next;
  logic [3:0][2:0][7:0] color_next;

  assign s4_ready = !s4_valid || pal_ready;
  assign s3_ready = !s3_valid || s4_ready;
  assign s2_ready = !s2_valid || s3_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;
  assign pal_valid = s4_valid;
  assign pal = s4_pal;

  // stage 2 logic
  always_comb begin
    logic [15:0] c0;
    logic [15:0] c1;
    logic [7:0]  a0;
    logic [7:0]  a1;
    c0 = s1_blk.color_block[15:0];
    c1 = s1_blk.color_block[31:16];
    a0 = s1_blk.alpha_block[7:0];
    a1 = s1_blk.alpha_block[15:8];
    e0_next[CH_RED]   = widen5(c0[15:11]);
    e0_next[CH_GREEN] = widen6(c0[10:5]);
    e0_next[CH_BLUE]  = widen5(c0[4:0]);
    e1_next[CH_RED]   = widen5(c1[15:11]);
    e1_next[CH_GREEN] = widen6(c1[10:5]);
    e1_next[CH_BLUE]  = widen5(c1[4:0]);
    four_next  = (c0 > c1) || (s1_fmt != FMT_DXT1);
    seven_next = a0 > a1;
    for (int k = 1; k <= 6; k++) begin
      if (seven_next) begin
        anum_next[k-1] = 11'(11'(7 - k) * 11'(a0) + 11'(k) * 11'(a1) + 11'd3);
      end else if (k <= 4) begin
        anum_next[k-1] = 11'(11'(5 - k) * 11'(a0) + 11'(k) * 11'(a1) + 11'd2);
      end else begin
        anum_next[k-1] = '0;
      end
    end
  end

  // stage 3 logic
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      if (s2_four) begin
        n2_next[ch] = {1'b0, s2_e0[ch], 1'b0} + 10'(s2_e1[ch]) + 10'd1;
        n3_next[ch] = 10'(s2_e0[ch]) + {1'b0, s2_e1[ch], 1'b0} + 10'd1;
      end else begin
        n2_next[ch] = 10'(s2_e0[ch]) + 10'(s2_e1[ch]);
        n3_next[ch] = '0;
      end
    end
    apal_next[0] = s2_ablk[7:0];
    apal_next[1] = s2_ablk[15:8];
    for (int k = 1; k <= 4; k++) begin
      apal_next[k+1] = s2_seven ? div7(s2_anum[k-1]) : div5(s2_anum[k-1]);
    end
    apal_next[6] = s2_seven ? div7(s2_anum[4]) : 8'd0;
    apal_next[7] = s2_seven ? div7(s2_anum[5]) : 8'd255;
  end

  // stage 4 logic
  always_comb begin
    color_next[0] = s3_e0;
    color_next[1] = s3_e1;
    for (int ch = 0; ch < 3; ch++) begin
      color_next[2][ch] = s3_four ? div3(s3_n2[ch]) : s3_n2[ch][8:1];
      color_next[3][ch] = s3_four ? div3(s3_n3[ch]) : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else begin
      if (s1_ready) s1_valid <= in_valid;
      if (s2_ready) s2_valid <= s1_valid;
      if (s3_ready) s3_valid <= s2_valid;
      if (s4_ready) s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_blk <= blk;
      s1_fmt <= fmt;
    end
    if (s2_ready && s1_valid) begin
      s2_e0    <= e0_next;
      s2_e1    <= e1_next;
      s2_four  <= four_next;
      s2_seven <= seven_next;
      s2_anum  <= anum_next;
      s2_fmt   <= s1_fmt;
      s2_cidx  <= s1_blk.color_block[63:32];
      s2_ablk  <= s1_blk.alpha_block;
    end
    if (s3_ready && s2_valid) begin
      s3_e0   <= s2_e0;
      s3_e1   <= s2_e1;
      s3_n2   <= n2_next;
      s3_n3   <= n3_next;
      s3_four <= s2_four;
      s3_apal <= apal_next;
      s3_fmt  <= s2_fmt;
      s3_cidx <= s2_cidx;
      s3_ablk <= s2_ablk;
    end
    if (s4_ready && s3_valid) begin
      s4_pal.color <= color_next;
      s4_pal.apal  <= s3_apal;
      s4_pal.four  <= s3_four;
      s4_pal.fmt   <= s3_fmt;
      s4_pal.cidx  <= s3_cidx;
      s4_pal.ablk  <= s3_ablk;
    end
  end

endmodule

// ----- src/dxt_block_decoder.sv -----
// S3TC block decoder (DXT1, DXT2/3, DXT4/5). A block is taken on a clock edge with start high
// and busy low; its 16 texels then come out as RGBA8 in raster order, one per cycle, each on
// the texel port for exactly one cycle with texel_valid high, and the sixteenth marked last.
// There is no back-pressure on the texel side: the receiver must take every word as it comes.
// The first texel passes through the four palette stages, the emitter's palette register and
// the texel output register; the 16 texels of a block then come out back to back, without gaps.
// Blocks are taken back to back while the palette pipeline has room, so a stream's pace is set
// by the one-texel-per-cycle output; busy rises once four blocks wait behind the one being
// emitted. block_format is written through the cfg channel (always ready) and must only
// change while no block is in flight; code 3 decodes as DXT4/5.
module dxt_block_decoder (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  dxt_pkg::dxt_in_t    blk,
  output logic                texel_valid,
  output dxt_pkg::dxt_texel_t texel,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_data
);
  import dxt_pkg::*;

`include "dxt_block_decoder_assert.svh"

  logic [1:0] fmt;
  logic       in_ready;
  logic       pal_valid;
  logic       pal_ready;
  dxt_pal_t   pal;

  // texel emitter
  logic       em_active;
  logic [3:0] em_cnt;
  dxt_pal_t   em_pal;
  dxt_texel_t texel_next;

  assign cfg_ready = 1'b1;
  assign busy      = !in_ready;

  // block_format register
  always_ff @(posedge clk) begin
    if (rst) begin
      fmt <= FMT_DXT1;
    end else if (cfg_valid && cfg_ready) begin
      fmt <= cfg_data;
    end
  end

  // four palette stages: endpoint widening, sums, divides
  dxt_pal u_pal (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .in_ready  (in_ready),
    .blk       (blk),
    .fmt       (fmt),
    .pal_valid (pal_valid),
    .pal_ready (pal_ready),
    .pal       (pal)
  );

  // next palette loads while the emitter is idle or as texel 15 of the current one goes out
  assign pal_ready = !em_active || (em_cnt == 4'd15);

  always_comb begin
    logic [1:0] ci;
    logic [3:0] nib;
    logic [5:0] aoff;
    logic [2:0] ai;
    ci   = em_pal.cidx[{em_cnt, 1'b0} +: 2];
    nib  = em_pal.ablk[{em_cnt, 2'b00} +: 4];
    aoff = 6'd16 + {1'b0, em_cnt, 1'b0} + {2'b00, em_cnt};
    ai   = em_pal.ablk[aoff +: 3];
    texel_next.red   = em_pal.color[ci][CH_RED];
    texel_next.green = em_pal.color[ci][CH_GREEN];
    texel_next.blue  = em_pal.color[ci][CH_BLUE];
    case (em_pal.fmt)
      FMT_DXT1: texel_next.alpha = (ci == 2'd3 && !em_pal.four) ? 8'd0 : 8'd255;
      FMT_DXT3: texel_next.alpha = {nib, nib};  // v*17
      default:  texel_next.alpha = em_pal.apal[ai];
    endcase
    texel_next.texel_index = em_cnt;
    texel_next.last        = (em_cnt == 4'd15);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      em_active   <= 1'b0;
      em_cnt      <= '0;
      texel_valid <= 1'b0;
    end else begin
      texel_valid <= em_active;
      if (em_active) em_cnt <= em_cnt + 4'd1;
      if (pal_ready) em_active <= pal_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pal_ready && pal_valid) em_pal <= pal;
    texel <= texel_next;
  end

  // a block's texels run without gaps, in order, starting from zero
  `DXT_ASSERT_NEXT(a_run_contig, texel_valid && !texel.last, texel_valid)
  `DXT_ASSERT_NEXT(a_idx_step, texel_valid && !texel.last,
                   texel.texel_index == 4'($past(texel.texel_index) + 4'd1))
  `DXT_ASSERT_NEXT(a_idx_first, !texel_valid, !texel_valid || texel.texel_index == 4'd0)
  `DXT_ASSERT_NEXT(a_idx_wrap, texel_valid && texel.last,
                   !texel_valid || texel.texel_index == 4'd0)

endmodule
